/* rtl/assert_macros.svh */
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge, reset included
`define RPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// checked only while out of reset
`define RPS_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

/* rtl/rps_pkg.sv */
package rps_pkg;

    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int DIR_FRAC_BITS_DEF = 14;

    // internal fixed point: Q30
    localparam int WQ = 30;
    localparam int MAG_W = WQ + 1;
    localparam logic [MAG_W-1:0] ONE_Q = MAG_W'(1) << WQ;

    localparam int CUBIC_STEPS  = WQ + 1;
    localparam int SQRT_STEPS   = WQ + 1;
    localparam int CORDIC_STEPS = 30;

    localparam int POLAR_LAT = 2 * CUBIC_STEPS + 1 + SQRT_STEPS;
    localparam int AZ_LAT    = CORDIC_STEPS + 2;
    localparam int WORLD_LAT = 3;
    localparam int TOTAL_LAT = POLAR_LAT + WORLD_LAT;

    localparam int AZ_W = 32;
    localparam int DENS_BITS = 14;
    localparam int DENS_SHIFT = 46;
    localparam logic [27:0] DENS_K = 28'd256336978;

    localparam int FRAME_N = 9;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] sin;
        logic [MAG_W-1:0] sq;
    } polar_t;

    typedef struct packed {
        logic signed [AZ_W-1:0] cs;
        logic signed [AZ_W-1:0] sn;
    } azim_t;

endpackage

/* rtl/rayleigh_phase_sampler_unit.sv */
// pipeline: 62 cubic root, 1 square, 31 square root and 3 world transform stages from input
//   transaction to result; azimuth rotation runs alongside
// throughput: one transaction per cycle; the whole pipeline holds while a result
//   waits on m_tready and an empty output register lets it move
// reset: aresetn clears the stage valid bits only, datapath registers are not reset
module rayleigh_phase_sampler_unit #(
    parameter int SAMPLE_BITS   = rps_pkg::SAMPLE_BITS_DEF,
    parameter int DIR_FRAC_BITS = rps_pkg::DIR_FRAC_BITS_DEF,
    parameter int DIR_BITS      = DIR_FRAC_BITS + 2,
    parameter int S_W = ((2 * SAMPLE_BITS + rps_pkg::FRAME_N * DIR_BITS + 7) / 8) * 8,
    parameter int M_W = ((3 * DIR_BITS + rps_pkg::DENS_BITS + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    // sample_u, sample_v, frame_s_x/y/z, frame_t_x/y/z, frame_n_x/y/z
    input  logic [S_W-1:0] s_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    // dir_x, dir_y, dir_z, density
    output logic [M_W-1:0] m_tdata
);

    localparam int LAT    = rps_pkg::TOTAL_LAT;
    localparam int PLAT   = rps_pkg::POLAR_LAT;
    localparam int AZ_PAD = rps_pkg::POLAR_LAT - rps_pkg::AZ_LAT;
    localparam int FN     = rps_pkg::FRAME_N;

    logic ce;
    logic [LAT-1:0] vld_reg, vld_next;

    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;
    assign m_tvalid = vld_reg[LAT-1];
    assign vld_next = {vld_reg[LAT-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= vld_next;
        end
    end

    logic [SAMPLE_BITS-1:0]       sample_u, sample_v;
    logic [FN-1:0][DIR_BITS-1:0]  frame_in;

    assign sample_u = s_tdata[SAMPLE_BITS-1:0];
    assign sample_v = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    generate
        for (genvar k = 0; k < FN; k++) begin : g_unpack
            assign frame_in[k] = s_tdata[2*SAMPLE_BITS + k*DIR_BITS +: DIR_BITS];
        end
    endgenerate

    rps_pkg::polar_t polar;
    rps_pkg::azim_t  azim;

    rps_polar #(.SAMPLE_BITS(SAMPLE_BITS)) u_polar (
        .aclk     (aclk),
        .ce       (ce),
        .sample_u (sample_u),
        .polar    (polar)
    );

    rps_azimuth #(.SAMPLE_BITS(SAMPLE_BITS)) u_azimuth (
        .aclk     (aclk),
        .ce       (ce),
        .sample_v (sample_v),
        .azim     (azim)
    );

    // align azimuth and frame with the polar result
    rps_pkg::azim_t              az_dly_reg    [AZ_PAD];
    logic [FN-1:0][DIR_BITS-1:0] frame_dly_reg [PLAT];

    always_ff @(posedge aclk) begin
        if (ce) begin
            az_dly_reg[0]    <= azim;
            frame_dly_reg[0] <= frame_in;
            for (int i = 1; i < AZ_PAD; i++) begin
                az_dly_reg[i] <= az_dly_reg[i-1];
            end
            for (int i = 1; i < PLAT; i++) begin
                frame_dly_reg[i] <= frame_dly_reg[i-1];
            end
        end
    end

    logic signed [DIR_BITS-1:0]     dir_x, dir_y, dir_z;
    logic [rps_pkg::DENS_BITS-1:0]  density;

    rps_world #(.DIR_FRAC_BITS(DIR_FRAC_BITS), .DIR_BITS(DIR_BITS)) u_world (
        .aclk    (aclk),
        .ce      (ce),
        .polar   (polar),
        .azim    (az_dly_reg[AZ_PAD-1]),
        .frame   (frame_dly_reg[PLAT-1]),
        .dir_x   (dir_x),
        .dir_y   (dir_y),
        .dir_z   (dir_z),
        .density (density)
    );

    assign m_tdata = M_W'({density, dir_z, dir_y, dir_x});

endmodule

/* rtl/rps_polar.sv */
module rps_polar #(
    parameter int SAMPLE_BITS = rps_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   ce,
    input  logic [SAMPLE_BITS-1:0] sample_u,
    output rps_pkg::polar_t        polar
);

    localparam int WQ  = rps_pkg::WQ;
    localparam int MW  = rps_pkg::MAG_W;
    localparam int TW  = WQ + 3;
    localparam int SQW = WQ + 2;
    localparam int LW  = WQ + 5;
    localparam int XW  = 2 * WQ + 1;
    localparam int RW  = 2 * WQ + 2;
    localparam int DW  = SAMPLE_BITS + 3;
    localparam int NC  = rps_pkg::CUBIC_STEPS;
    localparam int NS  = rps_pkg::SQRT_STEPS;

    // |8u - 4| scaled to Q30
    logic [DW-1:0] eight_u, four, diff;
    logic          neg0;
    logic [TW-1:0] target0;

    assign eight_u = {sample_u, 3'b000};
    assign four    = DW'(4) << SAMPLE_BITS;
    assign neg0    = eight_u < four;
    assign diff    = neg0 ? four - eight_u : eight_u - four;

    generate
        if (SAMPLE_BITS <= WQ) begin : g_tgt_up
            assign target0 = TW'(diff) << (WQ - SAMPLE_BITS);
        end else begin : g_tgt_dn
            assign target0 = TW'(diff >> (SAMPLE_BITS - WQ));
        end
    endgenerate

    // cubic root solve, one result bit per two stages
    logic [MW-1:0]  m_reg    [NC+1];
    logic [TW-1:0]  tgt_reg  [NC+1];
    logic           neg_reg  [NC+1];
    logic [MW-1:0]  ma_reg   [NC];
    logic [MW-1:0]  cand_reg [NC];
    logic [SQW-1:0] csq_reg  [NC];
    logic           ok_reg   [NC];
    logic [TW-1:0]  tga_reg  [NC];
    logic           nga_reg  [NC];

    assign m_reg[0]   = '0;
    assign tgt_reg[0] = target0;
    assign neg_reg[0] = neg0;

    generate
        for (genvar j = 0; j < NC; j++) begin : g_cubic
            localparam int B = WQ - j;
            logic [MW-1:0]      cand;
            logic [2*MW-1:0]    sq_full;
            logic [SQW+MW-1:0]  cube_full;
            logic [LW-1:0]      lhs;
            logic               take;

            assign cand    = m_reg[j] | (MW'(1) << B);
            assign sq_full = cand * cand;

            always_ff @(posedge aclk) begin
                if (ce) begin
                    ma_reg[j]   <= m_reg[j];
                    cand_reg[j] <= cand;
                    csq_reg[j]  <= sq_full[WQ +: SQW];
                    ok_reg[j]   <= cand <= rps_pkg::ONE_Q;
                    tga_reg[j]  <= tgt_reg[j];
                    nga_reg[j]  <= neg_reg[j];
                end
            end

            assign cube_full = csq_reg[j] * cand_reg[j];
            assign lhs = LW'(cube_full[SQW+MW-1:WQ]) + LW'(cand_reg[j])
                       + (LW'(cand_reg[j]) << 1);
            assign take = ok_reg[j] && (lhs <= LW'(tga_reg[j]));

            always_ff @(posedge aclk) begin
                if (ce) begin
                    m_reg[j+1]   <= take ? cand_reg[j] : ma_reg[j];
                    tgt_reg[j+1] <= tga_reg[j];
                    neg_reg[j+1] <= nga_reg[j];
                end
            end
        end
    endgenerate

    // cosine squared
    logic [2*MW-1:0] msq_full;
    logic [MW-1:0]   sqc_reg;
    logic [MW-1:0]   mc_reg;
    logic            nc_reg;

    assign msq_full = m_reg[NC] * m_reg[NC];

    always_ff @(posedge aclk) begin
        if (ce) begin
            sqc_reg <= msq_full[WQ +: MW];
            mc_reg  <= m_reg[NC];
            nc_reg  <= neg_reg[NC];
        end
    end

    // sine by bitwise square root of (1 - c^2) << 30
    logic [XW-1:0] x_reg   [NS+1];
    logic [RW-1:0] res_reg [NS+1];
    logic [MW-1:0] sm_reg  [NS+1];
    logic [MW-1:0] ssq_reg [NS+1];
    logic          sn_reg  [NS+1];

    assign x_reg[0]   = {rps_pkg::ONE_Q - sqc_reg, WQ'(0)};
    assign res_reg[0] = '0;
    assign sm_reg[0]  = mc_reg;
    assign ssq_reg[0] = sqc_reg;
    assign sn_reg[0]  = nc_reg;

    generate
        for (genvar k = 0; k < NS; k++) begin : g_sqrt
            logic [RW-1:0] bitv;
            logic [RW-1:0] trial;
            logic          ge;

            assign bitv  = RW'(1) << (2 * (WQ - k));
            assign trial = res_reg[k] + bitv;
            assign ge    = RW'(x_reg[k]) >= trial;

            always_ff @(posedge aclk) begin
                if (ce) begin
                    x_reg[k+1]   <= ge ? x_reg[k] - trial[XW-1:0] : x_reg[k];
                    res_reg[k+1] <= ge ? (res_reg[k] >> 1) + bitv : res_reg[k] >> 1;
                    sm_reg[k+1]  <= sm_reg[k];
                    ssq_reg[k+1] <= ssq_reg[k];
                    sn_reg[k+1]  <= sn_reg[k];
                end
            end
        end
    endgenerate

    assign polar.neg = sn_reg[NS];
    assign polar.mag = sm_reg[NS];
    assign polar.sin = res_reg[NS][MW-1:0];
    assign polar.sq  = ssq_reg[NS];

endmodule

/* rtl/rps_azimuth.sv */
module rps_azimuth #(
    parameter int SAMPLE_BITS = rps_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   ce,
    input  logic [SAMPLE_BITS-1:0] sample_v,
    output rps_pkg::azim_t         azim
);

    localparam int CW = 34;
    localparam int N  = rps_pkg::CORDIC_STEPS;
    localparam int WQ = rps_pkg::WQ;
    localparam int AZW = rps_pkg::AZ_W;
    localparam int PW = SAMPLE_BITS + 31;
    localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
    localparam logic signed [CW-1:0] ONE_C = CW'(1) <<< WQ;
    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;

    function automatic logic signed [CW-1:0] atan_q30(input int idx);
        logic [29:0] a;
        case (idx)
            0:  a = 30'h3243F6A8;
            1:  a = 30'h1DAC6705;
            2:  a = 30'h0FADBAFC;
            3:  a = 30'h07F56EA6;
            4:  a = 30'h03FEAB76;
            5:  a = 30'h01FFD55B;
            6:  a = 30'h00FFFAAA;
            7:  a = 30'h007FFF55;
            8:  a = 30'h003FFFEA;
            9:  a = 30'h001FFFFD;
            10: a = 30'h000FFFFF;
            11: a = 30'h0007FFFF;
            12: a = 30'h0003FFFF;
            13: a = 30'h0001FFFF;
            14: a = 30'h0000FFFF;
            15: a = 30'h00007FFF;
            16: a = 30'h00003FFF;
            17: a = 30'h00001FFF;
            18: a = 30'h00000FFF;
            19: a = 30'h000007FF;
            20: a = 30'h000003FF;
            21: a = 30'h000001FF;
            22: a = 30'h000000FF;
            23: a = 30'h0000007F;
            24: a = 30'h0000003F;
            25: a = 30'h0000001F;
            26: a = 30'h0000000F;
            27: a = 30'h00000008;
            28: a = 30'h00000004;
            29: a = 30'h00000002;
            default: a = '0;
        endcase
        return $signed({4'b0000, a});
    endfunction

    // shift toward zero
    function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] a,
                                                    input int s);
        logic [CW-1:0] mag;
        logic [CW-1:0] sh;
        mag = a[CW-1] ? -a : a;
        sh  = mag >> s;
        return a[CW-1] ? -$signed(sh) : $signed(sh);
    endfunction

    function automatic logic signed [AZW-1:0] clamp_one(input logic signed [CW-1:0] a);
        logic signed [CW-1:0] r;
        if (a > ONE_C) begin
            r = ONE_C;
        end else if (a < -ONE_C) begin
            r = -ONE_C;
        end else begin
            r = a;
        end
        return r[AZW-1:0];
    endfunction

    // quadrant and remaining angle in radians, Q30
    logic [PW-1:0] ang_prod;
    assign ang_prod = PW'(sample_v[SAMPLE_BITS-3:0]) * PW'(TWO_PI_Q30);

    logic signed [CW-1:0] x_reg [N+1];
    logic signed [CW-1:0] y_reg [N+1];
    logic signed [CW-1:0] a_reg [N+1];
    logic [1:0]           q_reg [N+1];

    assign x_reg[0] = CORDIC_GAIN;
    assign y_reg[0] = '0;

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_reg[0] <= $signed({3'b000, ang_prod[SAMPLE_BITS +: 31]});
            q_reg[0] <= sample_v[SAMPLE_BITS-1 -: 2];
        end
    end

    generate
        for (genvar i = 0; i < N; i++) begin : g_rot
            logic                 up;
            logic signed [CW-1:0] xs, ys;

            assign up = !a_reg[i][CW-1];
            assign xs = shr_tz(x_reg[i], i);
            assign ys = shr_tz(y_reg[i], i);

            always_ff @(posedge aclk) begin
                if (ce) begin
                    x_reg[i+1] <= up ? x_reg[i] - ys : x_reg[i] + ys;
                    y_reg[i+1] <= up ? y_reg[i] + xs : y_reg[i] - xs;
                    a_reg[i+1] <= up ? a_reg[i] - atan_q30(i) : a_reg[i] + atan_q30(i);
                    q_reg[i+1] <= q_reg[i];
                end
            end
        end
    endgenerate

    logic signed [AZW-1:0] qc, qs;
    rps_pkg::azim_t        rot_next, rot_reg;

    assign qc = clamp_one(x_reg[N]);
    assign qs = clamp_one(y_reg[N]);

    always_comb begin
        case (q_reg[N])
            QUAD_I: begin
                rot_next.cs = qc;
                rot_next.sn = qs;
            end
            QUAD_II: begin
                rot_next.cs = -qs;
                rot_next.sn = qc;
            end
            QUAD_III: begin
                rot_next.cs = -qc;
                rot_next.sn = -qs;
            end
            default: begin
                rot_next.cs = qs;
                rot_next.sn = -qc;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rot_reg <= rot_next;
        end
    end

    assign azim = rot_reg;

endmodule

/* rtl/rps_world.sv */
module rps_world #(
    parameter int DIR_FRAC_BITS = rps_pkg::DIR_FRAC_BITS_DEF,
    parameter int DIR_BITS      = DIR_FRAC_BITS + 2
) (
    input  logic                                        aclk,
    input  logic                                        ce,
    input  rps_pkg::polar_t                             polar,
    input  rps_pkg::azim_t                              azim,
    input  logic [rps_pkg::FRAME_N-1:0][DIR_BITS-1:0]   frame,
    output logic signed [DIR_BITS-1:0]                  dir_x,
    output logic signed [DIR_BITS-1:0]                  dir_y,
    output logic signed [DIR_BITS-1:0]                  dir_z,
    output logic [rps_pkg::DENS_BITS-1:0]               density
);

    localparam int WQ  = rps_pkg::WQ;
    localparam int MW  = rps_pkg::MAG_W;
    localparam int AZW = rps_pkg::AZ_W;
    localparam int FN  = rps_pkg::FRAME_N;
    localparam int PW  = DIR_BITS + AZW;
    localparam int SW  = PW + 2;
    localparam int DPW = 60;

    // stage 1: local vector and density product
    logic [AZW-1:0]    mc, ms;
    logic [2*MW-1:0]   pc, ps;
    logic [MW:0]       one_sq;

    assign mc     = azim.cs[AZW-1] ? -azim.cs : azim.cs;
    assign ms     = azim.sn[AZW-1] ? -azim.sn : azim.sn;
    assign pc     = polar.sin * mc[MW-1:0];
    assign ps     = polar.sin * ms[MW-1:0];
    assign one_sq = {1'b0, rps_pkg::ONE_Q} + (MW+1)'(polar.sq);

    logic signed [AZW-1:0]        loc0_reg, loc1_reg, loc2_reg;
    logic [DPW-1:0]               dp_reg;
    logic [FN-1:0][DIR_BITS-1:0]  fr_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            loc0_reg <= azim.cs[AZW-1] ? -$signed(AZW'(pc[WQ +: MW])) :
                                         $signed(AZW'(pc[WQ +: MW]));
            loc1_reg <= azim.sn[AZW-1] ? -$signed(AZW'(ps[WQ +: MW])) :
                                         $signed(AZW'(ps[WQ +: MW]));
            loc2_reg <= polar.neg ? -$signed(AZW'(polar.mag)) : $signed(AZW'(polar.mag));
            dp_reg   <= DPW'(one_sq) * DPW'(rps_pkg::DENS_K);
            fr_reg   <= frame;
        end
    end

    // stage 2: frame products, density rounding
    logic signed [PW-1:0] prod_reg [FN];
    logic [rps_pkg::DENS_BITS-1:0] dens_reg;
    logic [DPW-1:0] dsum;

    assign dsum = dp_reg + (DPW'(1) << (rps_pkg::DENS_SHIFT - 1));

    generate
        for (genvar k = 0; k < FN; k++) begin : g_prod
            logic signed [AZW-1:0] lv;
            assign lv = (k < 3) ? loc0_reg : ((k < 6) ? loc1_reg : loc2_reg);
            always_ff @(posedge aclk) begin
                if (ce) begin
                    prod_reg[k] <= PW'($signed(fr_reg[k])) * PW'(lv);
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (ce) begin
            dens_reg <= dsum[rps_pkg::DENS_SHIFT +: rps_pkg::DENS_BITS];
        end
    end

    // stage 3: world sum, round to nearest, saturate
    logic signed [DIR_BITS-1:0] dir_reg [3];
    logic [rps_pkg::DENS_BITS-1:0] dens_out_reg;

    generate
        for (genvar c = 0; c < 3; c++) begin : g_sum
            logic signed [SW-1:0] sum;
            logic [SW-1:0]        mag, rr;
            logic [DIR_BITS-1:0]  rsat;

            assign sum  = SW'(prod_reg[c]) + SW'(prod_reg[3+c]) + SW'(prod_reg[6+c]);
            assign mag  = sum[SW-1] ? -sum : sum;
            assign rr   = (mag + (SW'(1) << (WQ - 1))) >> WQ;
            assign rsat = (rr > (SW'(1) << DIR_FRAC_BITS)) ?
                          (DIR_BITS'(1) << DIR_FRAC_BITS) : rr[DIR_BITS-1:0];

            always_ff @(posedge aclk) begin
                if (ce) begin
                    dir_reg[c] <= sum[SW-1] ? -$signed(rsat) : $signed(rsat);
                end
            end
        end
    endgenerate

    // density keeps step with the direction
    always_ff @(posedge aclk) begin
        if (ce) begin
            dens_out_reg <= dens_reg;
        end
    end

    assign dir_x   = dir_reg[0];
    assign dir_y   = dir_reg[1];
    assign dir_z   = dir_reg[2];
    assign density = dens_out_reg;

endmodule

/* rtl/rps_checker.sv */
`include "assert_macros.svh"

module rps_checker #(
    parameter int DIR_FRAC_BITS = rps_pkg::DIR_FRAC_BITS_DEF,
    parameter int DIR_BITS      = DIR_FRAC_BITS + 2,
    parameter int M_W           = ((3 * DIR_BITS + rps_pkg::DENS_BITS + 7) / 8) * 8
) (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_tready,
    input logic           m_tvalid,
    input logic           m_tready,
    input logic [M_W-1:0] m_tdata
);

    localparam int LIM = 1 << DIR_FRAC_BITS;
    localparam logic [rps_pkg::DENS_BITS-1:0] DENS_MAX = rps_pkg::DENS_BITS'(8192);

    logic signed [DIR_BITS-1:0]    dir_z;
    logic [rps_pkg::DENS_BITS-1:0] density;

    assign dir_z   = m_tdata[2*DIR_BITS +: DIR_BITS];
    assign density = m_tdata[3*DIR_BITS +: rps_pkg::DENS_BITS];

    `RPS_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    `RPS_ASSERT_RUN(a_ready_follows, aclk, aresetn, s_tready == (!m_tvalid || m_tready), "input ready does not follow output")

    `RPS_ASSERT_RUN(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    `RPS_ASSERT_RUN(a_range, aclk, aresetn, m_tvalid |-> (density <= DENS_MAX) && (dir_z <= DIR_BITS'(LIM)) && (dir_z >= -$signed(DIR_BITS'(LIM))), "result out of range")

endmodule

bind rayleigh_phase_sampler_unit rps_checker #(
    .DIR_FRAC_BITS (DIR_FRAC_BITS),
    .DIR_BITS      (DIR_BITS),
    .M_W           (M_W)
) u_rps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
